// ===== rtl/minv_pkg.sv =====
// Shared constants and stream width helpers for the modular inverse block.
package minv_pkg;

    localparam int unsigned WIDTH_DEF = 32;

    function automatic int unsigned byte_round(input int unsigned bits);
        byte_round = ((bits + 7) / 8) * 8;
    endfunction

endpackage

// ===== rtl/minv_engine.sv =====
// Extended Euclidean sequencer around one shared shift, compare and subtract unit.
module minv_engine #(
    parameter int unsigned WIDTH = minv_pkg::WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] modulus,
    input  logic [WIDTH-1:0] value,
    input  logic             take,
    output logic             busy,
    output logic             done,
    output logic [WIDTH-1:0] inverse,
    output logic             found
);
    import minv_pkg::*;

    localparam int unsigned KW = (WIDTH > 2) ? $clog2(WIDTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_SUB,
        ST_FIX,
        ST_DONE
    } state_t;

    state_t           state_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] div_reg;
    logic [WIDTH-1:0] ud_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] n_reg;
    logic [KW-1:0]    k_reg;
    logic             reduce_reg;
    logic             neg_reg;
    logic             found_reg;
    logic [WIDTH-1:0] inverse_reg;

    logic [WIDTH:0]   div_dbl;
    logic             can_shift;
    logic             ge;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] acc_next;
    logic [WIDTH-1:0] fix_val;

    assign div_dbl   = {div_reg, 1'b0};
    assign can_shift = (div_dbl <= {1'b0, rem_reg});
    assign ge        = (div_reg <= rem_reg);
    assign rem_next  = ge ? (rem_reg - div_reg) : rem_reg;
    assign acc_next  = ge ? (acc_reg + ud_reg) : acc_reg;

    always_comb
    begin
        priority if (acc_reg == n_reg)
        begin
            fix_val = '0;
        end
        else if (neg_reg && (acc_reg != '0))
        begin
            fix_val = n_reg - acc_reg;
        end
        else
        begin
            fix_val = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        n_reg <= modulus;
                        if (modulus < WIDTH'(2))
                        begin
                            inverse_reg <= '0;
                            found_reg   <= 1'b0;
                            state_reg   <= ST_DONE;
                        end
                        else
                        begin
                            rem_reg    <= value;
                            div_reg    <= modulus;
                            ud_reg     <= '0;
                            acc_reg    <= '0;
                            k_reg      <= '0;
                            reduce_reg <= 1'b1;
                            neg_reg    <= 1'b0;
                            state_reg  <= ST_ALIGN;
                        end
                    end
                end
                ST_ALIGN:
                begin
                    if (can_shift)
                    begin
                        div_reg <= div_dbl[WIDTH-1:0];
                        ud_reg  <= {ud_reg[WIDTH-2:0], 1'b0};
                        k_reg   <= k_reg + KW'(1);
                    end
                    else
                    begin
                        state_reg <= ST_SUB;
                    end
                end
                ST_SUB:
                begin
                    if (k_reg != '0)
                    begin
                        rem_reg <= rem_next;
                        acc_reg <= acc_next;
                        div_reg <= {1'b0, div_reg[WIDTH-1:1]};
                        ud_reg  <= {1'b0, ud_reg[WIDTH-1:1]};
                        k_reg   <= k_reg - KW'(1);
                    end
                    else if (reduce_reg)
                    begin
                        reduce_reg <= 1'b0;
                        if (rem_next == '0)
                        begin
                            inverse_reg <= '0;
                            found_reg   <= 1'b0;
                            state_reg   <= ST_DONE;
                        end
                        else
                        begin
                            rem_reg   <= div_reg;
                            div_reg   <= rem_next;
                            ud_reg    <= WIDTH'(1);
                            acc_reg   <= '0;
                            state_reg <= ST_ALIGN;
                        end
                    end
                    else if (rem_next == '0)
                    begin
                        // The divisor is the last nonzero remainder, ud holds its coefficient.
                        found_reg <= (div_reg == WIDTH'(1));
                        acc_reg   <= ud_reg;
                        state_reg <= ST_FIX;
                    end
                    else
                    begin
                        rem_reg   <= div_reg;
                        div_reg   <= rem_next;
                        ud_reg    <= acc_next;
                        acc_reg   <= ud_reg;
                        neg_reg   <= ~neg_reg;
                        state_reg <= ST_ALIGN;
                    end
                end
                ST_FIX:
                begin
                    inverse_reg <= found_reg ? fix_val : '0;
                    state_reg   <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (take)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy    = (state_reg != ST_IDLE);
    assign done    = (state_reg == ST_DONE);
    assign inverse = inverse_reg;
    assign found   = found_reg;

endmodule

// ===== rtl/modular_inverse.sv =====
// Top level of the modular inverse block with stream ports and output register.
//
// Channel | Dir | Transfer fields
// s_*     | in  | tdata: modulus, value
// m_*     | out | tdata: inverse; tuser: found
//
// One item at a time; s_tready is high only while the sequencer is idle.
// Each Euclid round aligns the divisor and then subtracts through the single
// shift/compare/subtract unit, one quotient bit at a time.
// A result sits in the output register while the next item is already accepted.
// Reset is asynchronous and clears the sequencer state and m_tvalid.
module modular_inverse #(
    parameter int unsigned WIDTH = minv_pkg::WIDTH_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // Fields from bit 0: modulus, value.
    input  logic [minv_pkg::byte_round(2 * WIDTH)-1:0]   s_tdata,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // Fields from bit 0: inverse.
    output logic [minv_pkg::byte_round(WIDTH)-1:0]       m_tdata,
    // Fields from bit 0: found.
    output logic                                         m_tuser
);
    import minv_pkg::*;

    localparam int unsigned OUT_W = byte_round(WIDTH);

    logic             busy;
    logic             done;
    logic             take;
    logic [WIDTH-1:0] inverse;
    logic             found;
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic             m_tuser_reg;

    assign s_tready = ~busy;
    assign take     = done && (~m_tvalid_reg || m_tready);

    minv_engine #(
        .WIDTH (WIDTH)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (s_tvalid && s_tready),
        .modulus (s_tdata[WIDTH-1:0]),
        .value   (s_tdata[2*WIDTH-1:WIDTH]),
        .take    (take),
        .busy    (busy),
        .done    (done),
        .inverse (inverse),
        .found   (found)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= OUT_W'(inverse);
                m_tuser_reg  <= found;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
